/* rtl/core/assert_macros.svh */
// Assertion macros for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* rtl/core/lcgbr_pkg.sv */
// Package with word types and constants of the bounded LCG random generator.
`default_nettype none
package lcgbr_pkg;

    localparam logic [31:0] LCG_MULT          = 32'h015A_4E35;
    localparam logic [31:0] LCG_INC           = 32'd1;
    localparam logic signed [31:0] SMALL_BOUND_LIMIT = 32'sh0000_FFFF;
    localparam int unsigned HIGH_SHIFT        = 16;

    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_BOUNDED = 2'd1;
    localparam logic [1:0] MODE_RAW     = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        seed_value;
        logic signed [31:0] bound;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] value;
        logic [31:0]        state_word;
        logic [31:0]        draw_count;
    } t_out_word;

endpackage
`default_nettype wire

/* rtl/core/lcgbr_divider.sv */
// Iterative restoring divider that returns the remainder, one bit per cycle.
`default_nettype none
module lcgbr_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_remainder
);
    import lcgbr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_step;
    logic [31:0]          r_rem;
    logic [31:0]          r_dvd;
    logic [31:0]          r_dvs;

    logic [31:0] rem_sh;
    logic [32:0] diff;
    logic [31:0] n_rem;

    // The partial remainder stays below the divisor, which is below 2^31,
    // so the shifted value always fits in 32 bits.
    always_comb begin
        rem_sh = {r_rem[30:0], r_dvd[31]};
        diff   = {1'b0, rem_sh} - {1'b0, r_dvs};
        n_rem  = diff[32] ? rem_sh : diff[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_dvd  <= {r_dvd[30:0], 1'b0};
                r_step <= r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

/* rtl/core/lcg_bounded_random.sv */
// Bounded 32-bit linear congruential random generator, top level.
//
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per item:
// a seed load, a raw draw or a bounded draw. Output channel (o_out_valid /
// i_out_ready / o_out_word) returns exactly one word per item with the drawn
// value, the generator state and the count of advances since the last load.
// Only one item is in flight; o_in_ready is high while the sequencer is idle.
// A seed load, an unused mode or a bounded draw with a bound that is not
// positive goes from ST_IDLE straight to ST_DONE; a raw draw passes through
// ST_MUL, ST_ADD and ST_SETUP first, and a bounded draw then waits in ST_DIV
// for the remainder divider, which settles one bit per cycle over 32 bits.
// The output word sits in a register: the next item is accepted while it
// waits, and a finished item holds in its last step until the register frees.
// Reset clears the generator state and the draw count to zero and empties
// the output register.
`default_nettype none
`include "assert_macros.svh"
module lcg_bounded_random (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire lcgbr_pkg::t_in_word   i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output lcgbr_pkg::t_out_word       o_out_word
);
    import lcgbr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_ADD   = 6'b000100,
        ST_SETUP = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state             r_st;
    logic [31:0]        r_state;
    logic [31:0]        r_count;
    logic [31:0]        r_prod;
    logic [1:0]         r_mode;
    logic signed [31:0] r_bound;
    logic               r_neg;
    logic signed [31:0] r_value;
    logic               r_out_valid;
    t_out_word          r_out;

    logic        in_accept;
    logic [31:0] raw_abs;
    logic        small_bound;
    logic        div_start;
    logic [31:0] div_dividend;
    logic        div_done;
    logic [31:0] div_rem;

    assign in_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_st == ST_IDLE);

    // The absolute value of 0x80000000 wraps back to itself, which is the
    // required raw result. Read as unsigned it is also the right magnitude.
    always_comb begin
        raw_abs      = r_state[31] ? (32'd0 - r_state) : r_state;
        small_bound  = (r_bound < SMALL_BOUND_LIMIT);
        div_dividend = small_bound ? (raw_abs >> HIGH_SHIFT) : raw_abs;
        div_start    = (r_st == ST_SETUP) && (r_mode == MODE_BOUNDED);
    end

    lcgbr_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (r_bound),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_state     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the last step the output register is refilled directly.
            if (o_out_valid && i_out_ready && r_st != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_mode  <= i_in_word.mode;
                        r_bound <= i_in_word.bound;
                        r_value <= '0;
                        if (i_in_word.mode == MODE_LOAD) begin
                            r_state <= i_in_word.seed_value;
                            r_count <= '0;
                            r_st    <= ST_DONE;
                        end else if (i_in_word.mode == MODE_RAW ||
                                     (i_in_word.mode == MODE_BOUNDED &&
                                      i_in_word.bound > 32'sd0)) begin
                            r_st <= ST_MUL;
                        end else begin
                            r_st <= ST_DONE;
                        end
                    end
                end
                ST_MUL: begin
                    r_prod <= r_state * LCG_MULT;
                    r_st   <= ST_ADD;
                end
                ST_ADD: begin
                    r_state <= r_prod + LCG_INC;
                    r_count <= r_count + 32'd1;
                    r_st    <= ST_SETUP;
                end
                ST_SETUP: begin
                    r_neg <= raw_abs[31];
                    if (r_mode == MODE_BOUNDED) begin
                        r_st <= ST_DIV;
                    end else begin
                        r_value <= raw_abs;
                        r_st    <= ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        // Only the most negative raw number has a negative
                        // dividend; the truncating remainder takes its sign.
                        r_value <= r_neg ? (32'sd0 - div_rem) : div_rem;
                        r_st    <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid      <= 1'b1;
                        r_out.value      <= r_value;
                        r_out.state_word <= r_state;
                        r_out.draw_count <= r_count;
                        r_st             <= ST_IDLE;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `ASSERT_IMPLIES(a_div_done_in_div, i_clk, i_rst_n, div_done, r_st == ST_DIV)
    `ASSERT_IMPLIES(a_rem_below_bound, i_clk, i_rst_n, div_done, div_rem < r_bound)
    `ASSERT_NEXT(a_load_clears_count, i_clk, i_rst_n, in_accept && i_in_word.mode == MODE_LOAD, r_count == 32'd0)
    `ASSERT_NEXT(a_advance_counts, i_clk, i_rst_n, r_st == ST_ADD, r_count == $past(r_count) + 32'd1)

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the bounded LCG random generator.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcgbr_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned RANDOM_WORDS = 1900;
    localparam int unsigned QUIET_TAIL = 200;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 50;

    // Tracks the generator state, predicts every result word and checks it.
    class draw_scoreboard;
        logic [31:0] gen_state;
        logic [31:0] advances;
        t_out_word   expected_draws[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned n_load, n_raw, n_small, n_large, n_nonpos, n_unused;

        function new();
            gen_state = '0;
            advances = '0;
            mismatches = 0;
            checked = 0;
            n_load = 0;
            n_raw = 0;
            n_small = 0;
            n_large = 0;
            n_nonpos = 0;
            n_unused = 0;
        endfunction

        function void report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endfunction

        // One generator step; returns the magnitude of the new state as signed,
        // except that the most negative state stays negative.
        function longint step_raw();
            longint s;
            advances = advances + 32'd1;
            gen_state = gen_state * LCG_MULT + LCG_INC;
            s = longint'(signed'(gen_state));
            if (gen_state == 32'h8000_0000) begin
                return s;
            end
            return (s < 0) ? -s : s;
        endfunction

        function void note_word(t_in_word w);
            t_out_word r;
            longint b;
            longint raw;
            longint v;
            v = 0;
            case (w.mode)
                MODE_LOAD: begin
                    gen_state = w.seed_value;
                    advances = '0;
                    n_load++;
                end
                MODE_BOUNDED: begin
                    b = longint'(signed'(w.bound));
                    if (b > 0) begin
                        raw = step_raw();
                        // Small bounds use the high half; >>> floors like the hardware.
                        if (b < longint'(SMALL_BOUND_LIMIT)) begin
                            v = (raw >>> HIGH_SHIFT) % b;
                            n_small++;
                        end else begin
                            v = raw % b;
                            n_large++;
                        end
                    end else begin
                        n_nonpos++;
                    end
                end
                MODE_RAW: begin
                    v = step_raw();
                    n_raw++;
                end
                default: begin
                    n_unused++;
                end
            endcase
            r.value = v[31:0];
            r.state_word = gen_state;
            r.draw_count = advances;
            expected_draws.push_back(r);
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (expected_draws.size() == 0) begin
                report($sformatf("result word %h with no prediction pending", got));
                return;
            end
            want = expected_draws.pop_front();
            checked++;
            if (got.value !== want.value) begin
                report($sformatf("value %h, predicted %h", got.value, want.value));
            end
            if (got.state_word !== want.state_word) begin
                report($sformatf("state_word %h, predicted %h",
                                 got.state_word, want.state_word));
            end
            if (got.draw_count !== want.draw_count) begin
                report($sformatf("draw_count %h, predicted %h",
                                 got.draw_count, want.draw_count));
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    draw_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int unsigned words_accepted = 0;
    bit          quiet = 1'b0;

    lcg_bounded_random dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    // Both handshakes are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_word(i_in_word);
                words_accepted <= words_accepted + 1;
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_word(o_out_word);
            end
        end
    end

    // Result side: random stall bursts, one long hold to back the block up,
    // and no stalls at all during the quiet tail.
    initial begin
        bit held_long;
        held_long = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held_long && words_accepted >= 400) begin
                held_long = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Seed whose next state is the given one: multiply by the inverse of the
    // multiplier, found by Newton iteration modulo 2^32.
    function automatic logic [31:0] seed_before(logic [31:0] next_state);
        logic [31:0] inv;
        inv = LCG_MULT;
        repeat (5) inv = inv * (32'd2 - LCG_MULT * inv);
        return (next_state - LCG_INC) * inv;
    endfunction

    task automatic put_word(logic [1:0] mode, logic [31:0] seed, logic [31:0] bound);
        t_in_word w;
        w.mode = mode;
        w.seed_value = seed;
        w.bound = bound;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic idle_input(int unsigned n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic run_directed();
        logic [31:0] to_most_neg;
        to_most_neg = seed_before(32'h8000_0000);
        put_word(MODE_BOUNDED, 32'hFFFF_FFFF, 32'd10);
        put_word(MODE_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_word(MODE_LOAD, 32'hFFFF_FFFF, 32'h0);
        put_word(MODE_RAW, 32'h0, 32'h7FFF_FFFF);
        put_word(MODE_LOAD, 32'h0, 32'h8000_0000);
        // The most negative raw draw, alone and through both bound paths.
        put_word(MODE_LOAD, to_most_neg, 32'd5);
        put_word(MODE_RAW, 32'h0, 32'd5);
        put_word(MODE_LOAD, to_most_neg, 32'd100);
        put_word(MODE_BOUNDED, 32'h0, 32'd100);
        put_word(MODE_LOAD, to_most_neg, 32'd0);
        put_word(MODE_BOUNDED, 32'h0, 32'h7FFF_FFFF);
        put_word(MODE_LOAD, to_most_neg, 32'd0);
        put_word(MODE_BOUNDED, 32'h0, 32'h0000_FFFF);
        // Bounds that are not positive leave the state alone.
        put_word(MODE_BOUNDED, 32'h1234_5678, 32'd0);
        put_word(MODE_BOUNDED, 32'h0, 32'hFFFF_FFFF);
        put_word(MODE_BOUNDED, 32'h0, 32'h8000_0000);
        put_word(MODE_BOUNDED, 32'h0, 32'd1);
        put_word(MODE_BOUNDED, 32'h0, 32'h0000_FFFE);
        put_word(MODE_BOUNDED, 32'h0, 32'h0001_0000);
        put_word(MODE_LOAD, seed_before(32'hFFFF_FFFF), 32'd0);
        put_word(MODE_RAW, 32'h0, 32'd0);
        put_word(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_word(MODE_RAW, 32'h0, 32'd0);
    endtask

    task automatic run_random();
        int unsigned pick;
        logic [1:0]  mode;
        logic [31:0] seed;
        logic [31:0] bound;
        for (int unsigned k = 0; k < RANDOM_WORDS; k++) begin
            if (k >= RANDOM_WORDS - QUIET_TAIL) begin
                quiet = 1'b1;
            end
            if (!quiet && $urandom_range(0, 3) == 0) begin
                idle_input($urandom_range(1, 10));
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                mode = MODE_LOAD;
            end else if (pick < 35) begin
                mode = MODE_RAW;
            end else if (pick < 98) begin
                mode = MODE_BOUNDED;
            end else begin
                mode = MODE_UNUSED;
            end
            seed = $urandom();
            if (mode == MODE_LOAD && $urandom_range(0, 3) == 0) begin
                seed = seed_before(32'h8000_0000);
            end
            case ($urandom_range(0, 9))
                0, 1, 2: bound = $urandom_range(1, 100);
                3:       bound = $urandom_range(1, 3);
                4:       bound = $urandom_range(1, 32'h0000_FFFE);
                5:       bound = $urandom_range(32'h0000_FFFD, 32'h0001_0001);
                6:       bound = $urandom_range(32'h0001_0000, 32'h7FFF_FFFF);
                7:       bound = $urandom();
                8:       bound = 32'd0 - $urandom_range(0, 1000);
                default: bound = $urandom_range(101, 5000);
            endcase
            put_word(mode, seed, bound);
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d result words in %0d cycles: %0d seed loads, %0d raw draws",
                 sb.checked, cycle_count, sb.n_load, sb.n_raw);
        $display("Bounded draws: %0d high-half, %0d full-width, %0d non-positive; %0d unused",
                 sb.n_small, sb.n_large, sb.n_nonpos, sb.n_unused);
        if (sb.mismatches == 0 && sb.expected_draws.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/lcgbr_pkg.sv
rtl/core/lcgbr_divider.sv
rtl/core/lcg_bounded_random.sv
dv/tb_top.sv
